// File: hdl/mmpq_pkg.sv
`timescale 1ns / 1ps
package mmpq_pkg;

  localparam int DATA_W       = 32;
  localparam int ACTION_W     = 2;
  localparam int COUNT_OUT_W  = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL_MAX = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL_MIN = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// File: hdl/min_max_priority_queue_top.sv
`timescale 1ns / 1ps
// Double-ended priority queue of signed 32-bit values, kept in ascending order in
// a single-port-write, single-port-read ring memory. Each item inserts a value,
// deletes the maximum or deletes the minimum, and returns one result with the
// current maximum and minimum (0 when empty), the count and a refusal flag.
// Delete-max and delete-min pass from acceptance through S_FETCH (one memory read
// to refetch the new end) and S_CAPT to the result register, or go straight to
// it when the delete empties the queue, as does a refused item or unused action
// code. An insert walks the insertion point down one entry at a time (memory
// read, then compare and write) past each stored value greater than the new one,
// writing at the bottom without a compare when the new value goes below every
// stored value. The block accepts no item while one is in progress; a finished
// result waits in its output register while the next item is accepted, and the
// next result then holds the input stalled until that register is free.
module min_max_priority_queue_top
  import mmpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ACTION_W-1:0]    action,
  input  logic signed [DATA_W-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [DATA_W-1:0] max_value,
  output logic signed [DATA_W-1:0] min_value,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   ignored
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] HEAD_LAST = IW'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_FETCH   = 3'd3;
  localparam logic [2:0] S_CAPT    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]          state;
  logic [ACTION_W-1:0] act;
  word_t               val;
  word_t               max_reg;
  word_t               min_reg;
  logic [CW-1:0]       count;
  logic [CW-1:0]       pos;
  logic [IW-1:0]       head;
  logic                refused;

  logic                wr_en;
  logic [IW-1:0]       wr_idx;
  word_t               wr_data;
  logic                rd_en;
  logic [IW-1:0]       rd_idx;
  word_t               rd_data;
  logic [CW-1:0]       pos_dec;
  logic [CW+COUNT_OUT_W-1:0] count_wide;

  assign in_stall = (state != S_IDLE);
  assign pos_dec  = pos - 1'b1;

  mmpq_ring #(
    .CAPACITY(CAPACITY)
  ) u_ring (
    .clk    (clk),
    .head   (head),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_data(rd_data)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pos[IW-1:0];
    wr_data = val;
    rd_en   = 1'b0;
    rd_idx  = pos_dec[IW-1:0];
    unique case (state)
      S_INS_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data > val) begin
          wr_data = rd_data;
        end
      end
      S_FETCH: begin
        rd_en  = 1'b1;
        rd_idx = pos[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            val <= value;
            priority if (action == ACT_INSERT) begin
              if (count == CAP_C) begin
                refused <= 1'b1;
                state   <= S_DONE;
              end else begin
                refused <= 1'b0;
                pos     <= count;
                state   <= S_INS_RD;
                if (count == '0 || value > max_reg) max_reg <= value;
                if (count == '0 || value < min_reg) min_reg <= value;
              end
            end else if (action == ACT_DEL_MAX || action == ACT_DEL_MIN) begin
              if (count == '0) begin
                refused <= 1'b1;
                state   <= S_DONE;
              end else begin
                refused <= 1'b0;
                count   <= count - 1'b1;
                if (action == ACT_DEL_MAX) begin
                  pos <= count - CW'(2);
                end else begin
                  pos  <= '0;
                  head <= (head == HEAD_LAST) ? '0 : head + 1'b1;
                end
                // refetch the new end only when something remains
                if (count != CW'(1)) begin
                  state <= S_FETCH;
                end else begin
                  state <= S_DONE;
                end
              end
            end else begin
              refused <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_data > val) begin
            pos   <= pos_dec;
            state <= S_INS_RD;
          end else begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          state <= S_CAPT;
        end
        S_CAPT: begin
          if (act == ACT_DEL_MAX) begin
            max_reg <= rd_data;
          end else begin
            min_reg <= rd_data;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_wide = {{COUNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      max_value   <= (count == '0) ? '0 : max_reg;
      min_value   <= (count == '0) ? '0 : min_reg;
      entry_count <= count_wide[COUNT_OUT_W-1:0];
      ignored     <= refused;
    end
  end

endmodule

// File: hdl/mmpq_ring.sv
`timescale 1ns / 1ps
// Ring store addressed relative to the head, so delete-min just moves the head.
module mmpq_ring
  import mmpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic [$clog2(CAPACITY)-1:0] head,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_idx,
  input  word_t                       wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_idx,
  output word_t                       rd_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW:0] CAP_L = (IW+1)'(CAPACITY);

  word_t mem [CAPACITY];

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [IW-1:0] idx);
    logic [IW:0] s;
    logic [IW:0] w;
    s = {1'b0, base} + {1'b0, idx};
    w = (s >= CAP_L) ? (s - CAP_L) : s;
    return w[IW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[phys(head, wr_idx)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[phys(head, rd_idx)];
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import mmpq_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER = 60;

  typedef struct {
    logic [ACTION_W-1:0] act;
    word_t               val;
    logic                wait_empty;
  } queue_op_t;

  typedef struct {
    word_t                  max_v;
    word_t                  min_v;
    logic [COUNT_OUT_W-1:0] cnt;
    logic                   refused;
  } queue_status_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [ACTION_W-1:0]    action;
  logic signed [DATA_W-1:0] value;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [DATA_W-1:0] max_value;
  logic signed [DATA_W-1:0] min_value;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   ignored;

  queue_op_t     pending_ops[$];
  queue_status_t expected_status[$];
  word_t         sorted_vals[$];

  int            error_count = 0;
  int            accepted_total = 0;
  int            planned_count = 0;
  logic          in_took;
  int            burst_left = 0;
  int            gap_left = 0;
  int            stall_mode = 0;
  int            stall_phase_left = 0;
  int            long_hold_left = 0;
  logic          long_hold_done = 1'b0;
  queue_op_t     next_op;
  queue_status_t got_status;
  queue_status_t want_status;

  min_max_priority_queue_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .max_value  (max_value),
    .min_value  (min_value),
    .entry_count(entry_count),
    .ignored    (ignored)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    action    = ACT_INSERT;
    value     = '0;
    in_took   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Sorted shadow of the queue; equal values go after existing copies.
  task automatic queue_step(input logic [ACTION_W-1:0] act, input word_t val,
                            output queue_status_t st);
    int pos;
    int i;
    st.refused = 1'b0;
    case (act)
      ACT_INSERT: begin
        if (sorted_vals.size() >= QUEUE_DEPTH) begin
          st.refused = 1'b1;
        end else begin
          pos = sorted_vals.size();
          for (i = 0; i < sorted_vals.size(); i++) begin
            if (sorted_vals[i] > val) begin
              pos = i;
              break;
            end
          end
          sorted_vals.insert(pos, val);
        end
      end
      ACT_DEL_MAX: begin
        if (sorted_vals.size() == 0) st.refused = 1'b1;
        else void'(sorted_vals.pop_back());
      end
      ACT_DEL_MIN: begin
        if (sorted_vals.size() == 0) st.refused = 1'b1;
        else void'(sorted_vals.pop_front());
      end
      default: ;
    endcase
    if (sorted_vals.size() == 0) begin
      st.max_v = '0;
      st.min_v = '0;
    end else begin
      st.max_v = sorted_vals[sorted_vals.size()-1];
      st.min_v = sorted_vals[0];
    end
    st.cnt = COUNT_OUT_W'(sorted_vals.size());
  endtask

  task automatic add_op(input logic [ACTION_W-1:0] act, input word_t val,
                        input logic wait_empty = 1'b0);
    queue_op_t op;
    op.act        = act;
    op.val        = val;
    op.wait_empty = wait_empty;
    pending_ops = {pending_ops, op};
    if (act == ACT_INSERT && planned_count < QUEUE_DEPTH) planned_count++;
    else if ((act == ACT_DEL_MAX || act == ACT_DEL_MIN) && planned_count > 0) planned_count--;
  endtask

  function automatic word_t pick_value(input int mode);
    case (mode)
      0: pick_value = word_t'($urandom);
      1: pick_value = word_t'($urandom_range(0, 6)) - 32'sd3;
      default: begin
        case ($urandom_range(0, 4))
          0: pick_value = WORD_MIN + word_t'($urandom_range(0, 2));
          1: pick_value = WORD_MAX - word_t'($urandom_range(0, 2));
          2: pick_value = '0;
          3: pick_value = -32'sd1;
          default: pick_value = word_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Driver: present items from the pending queue in bursts with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled item
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].wait_empty && expected_status.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_op = pending_ops.pop_front();
        action   <= next_op.act;
        value    <= next_op.val;
        in_valid <= 1'b1;
        burst_left--;
      end
    end
  end

  // Receiver: stall in phases of random density, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!long_hold_done && accepted_total >= LONG_HOLD_AFTER) begin
        long_hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        out_stall <= 1'b1;
        long_hold_left--;
      end else begin
        if (stall_phase_left == 0) begin
          stall_mode       = $urandom_range(0, 2);
          stall_phase_left = $urandom_range(10, 80);
        end
        stall_phase_left--;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result with none expected: max %0d min %0d cnt %0d ign %0b",
                                    max_value, min_value, entry_count, ignored));
        end else begin
          want_status = expected_status.pop_front();
          if (max_value !== want_status.max_v)
            report_mismatch($sformatf("max_value got %0d want %0d",
                                      max_value, want_status.max_v));
          if (min_value !== want_status.min_v)
            report_mismatch($sformatf("min_value got %0d want %0d",
                                      min_value, want_status.min_v));
          if (entry_count !== want_status.cnt)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      entry_count, want_status.cnt));
          if (ignored !== want_status.refused)
            report_mismatch($sformatf("ignored got %0b want %0b",
                                      ignored, want_status.refused));
        end
      end
      if (in_valid && !in_stall) begin
        queue_step(action, value, got_status);
        expected_status = {expected_status, got_status};
        accepted_total++;
      end
    end
  end

  initial begin : stimulus
    int seg_kind;
    int seg_len;
    int val_mode;
    int r;
    int n_rand;
    logic [ACTION_W-1:0] act;

    // Directed: refusals on empty, extremes, duplicates, unused code.
    add_op(ACT_DEL_MAX, 32'sd5);
    add_op(ACT_DEL_MIN, -32'sd5);
    add_op(ACT_UNUSED, WORD_MAX);
    add_op(ACT_INSERT, '0);
    add_op(ACT_INSERT, WORD_MIN);
    add_op(ACT_INSERT, WORD_MAX);
    add_op(ACT_INSERT, -32'sd1);
    add_op(ACT_INSERT, '0);
    add_op(ACT_INSERT, WORD_MAX);
    add_op(ACT_UNUSED, WORD_MIN);
    add_op(ACT_DEL_MAX, '0);
    add_op(ACT_DEL_MAX, '0);
    add_op(ACT_DEL_MIN, '0);
    add_op(ACT_DEL_MIN, '0);
    add_op(ACT_DEL_MIN, '0);
    add_op(ACT_DEL_MAX, '0);
    add_op(ACT_DEL_MIN, '0);
    add_op(ACT_INSERT, 32'sd1);
    add_op(ACT_INSERT, -32'sd2);
    add_op(ACT_DEL_MAX, '0);
    add_op(ACT_DEL_MAX, '0);

    // Fill past full, then drain past empty; start only once the queue is quiet.
    n_rand = 0;
    val_mode = 0;
    while (planned_count < QUEUE_DEPTH || n_rand < QUEUE_DEPTH + 3) begin
      add_op(ACT_INSERT, pick_value(n_rand % 3), n_rand == 0);
      n_rand++;
    end
    for (int k = 0; k < QUEUE_DEPTH + 2; k++) begin
      add_op($urandom_range(0, 1) ? ACT_DEL_MAX : ACT_DEL_MIN, pick_value(0));
      n_rand++;
    end

    // Random segments biased toward filling, draining, mixing or noise.
    while (n_rand < RANDOM_ITEMS) begin
      seg_kind = $urandom_range(0, 3);
      seg_len  = $urandom_range(10, 60);
      val_mode = $urandom_range(0, 2);
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        case (seg_kind)
          0:       act = (r < 75) ? ACT_INSERT : (r < 87) ? ACT_DEL_MAX : ACT_DEL_MIN;
          1:       act = (r < 20) ? ACT_INSERT : (r < 60) ? ACT_DEL_MAX : ACT_DEL_MIN;
          2:       act = (r < 48) ? ACT_INSERT : (r < 74) ? ACT_DEL_MAX : ACT_DEL_MIN;
          default: act = ACTION_W'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 49) == 0) act = ACT_UNUSED;
        add_op(act, pick_value(val_mode), n_rand == 300);
        n_rand++;
      end
    end

    @(negedge rst);
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (2 * QUEUE_DEPTH + 10) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
